### design/point_triangle_region_classifier_assert.svh
// Assertion macros used by the checker file.
`ifndef POINT_TRIANGLE_REGION_CLASSIFIER_ASSERT_SVH
`define POINT_TRIANGLE_REGION_CLASSIFIER_ASSERT_SVH

// Implication checked on every clock edge out of reset.
`define PTRC_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Property checked on every clock edge, reset included.
`define PTRC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

### design/ptrc_pkg.sv
// ----------------------------------------------------------------------------
// ptrc_pkg
// Widths, types and lane tables of the point/triangle region classifier.
// ----------------------------------------------------------------------------
package ptrc_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int DIFF_W      = COORD_WIDTH + 1;
   localparam int MUL_W       = 2 * DIFF_W;
   localparam int CROSS_W     = MUL_W + 1;
   // cross components split into an unsigned low half and a signed high half
   localparam int LO_W        = COORD_WIDTH + 1;
   localparam int HI_W        = CROSS_W - LO_W;
   localparam int PART_W      = 2 * HI_W;
   localparam int DOT_W       = 4 * COORD_WIDTH + 8;
   localparam int STAGES      = 7;
   localparam int LANES       = 4;
   localparam int REGION_W    = 4;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]      diff_type;
   typedef logic signed [MUL_W-1:0]       mul_type;
   typedef logic signed [CROSS_W-1:0]     cross_type;
   typedef logic signed [HI_W-1:0]        half_type;
   typedef logic signed [PART_W-1:0]      part_type;
   typedef logic signed [DOT_W-1:0]       dot_type;
   typedef logic [REGION_W-1:0]           region_type;

   typedef enum logic [1:0] {
      EDGE_NONE = 2'd0,
      EDGE_12   = 2'd1,
      EDGE_23   = 2'd2,
      EDGE_31   = 2'd3
   } edge_type;

   localparam region_type REGION_INSIDE  = 4'd0;
   localparam region_type REGION_A_TRUE  = 4'd4;
   localparam region_type REGION_A_FALSE = 4'd5;
   localparam region_type REGION_B_TRUE  = 4'd6;
   localparam region_type REGION_B_FALSE = 4'd7;
   localparam region_type REGION_C_TRUE  = 4'd8;
   localparam region_type REGION_C_FALSE = 4'd9;

   // point order per lane: p1, p2, p3, test point (0 a, 1 b, 2 c, 3 q)
   localparam int LANE_PT [LANES][4] = '{
      '{0, 1, 2, 3},
      '{3, 1, 2, 0},
      '{0, 3, 2, 1},
      '{0, 1, 3, 2}
   };
   // cross product operands: x12, x23, x31
   localparam int CROSS_U [3] = '{0, 1, 2};
   localparam int CROSS_V [3] = '{1, 2, 0};
   localparam int NEXT1   [3] = '{1, 2, 0};
   localparam int NEXT2   [3] = '{2, 0, 1};
   // second operand of each dot product with x12: x31, then x23
   localparam int DOT_Y   [2] = '{2, 1};

endpackage

### design/point_triangle_region_classifier.sv
// ----------------------------------------------------------------------------
// point_triangle_region_classifier
// Classifies a query point against a 3D triangle by exact cross products.
// ----------------------------------------------------------------------------
// Takes one item per cycle while the output is not stalled and returns its
// region code through a seven-stage pipeline (differences, cross multiplies,
// cross subtracts, split dot multiplies, partial recombination, dot sums and
// sign, code select). The main test and the three swapped-vertex tests run in
// four parallel lanes. A stall at the output holds in the same cycle each full
// stage with no empty stage ahead of it; stages behind a bubble still advance,
// so bubbles are squeezed out and the input keeps flowing until all seven stages hold an item.
module point_triangle_region_classifier (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ptrc_pkg::coord_type   req_a_x,
   input  ptrc_pkg::coord_type   req_a_y,
   input  ptrc_pkg::coord_type   req_a_z,
   input  ptrc_pkg::coord_type   req_b_x,
   input  ptrc_pkg::coord_type   req_b_y,
   input  ptrc_pkg::coord_type   req_b_z,
   input  ptrc_pkg::coord_type   req_c_x,
   input  ptrc_pkg::coord_type   req_c_y,
   input  ptrc_pkg::coord_type   req_c_z,
   input  ptrc_pkg::coord_type   req_q_x,
   input  ptrc_pkg::coord_type   req_q_y,
   input  ptrc_pkg::coord_type   req_q_z,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ptrc_pkg::region_type  rsp_region_code
);

   localparam int N = ptrc_pkg::STAGES;
   localparam int L = ptrc_pkg::LANES;

   logic [N-1:0] v_ff, v_in, en;

   ptrc_pkg::coord_type  pt [4][3];
   ptrc_pkg::diff_type   diff_ff [L][3][3], diff_in [L][3][3];
   ptrc_pkg::mul_type    mul_ff [L][3][3][2], mul_in [L][3][3][2];
   ptrc_pkg::cross_type  cross_ff [L][3][3], cross_in [L][3][3];
   ptrc_pkg::part_type   part_ff [L][2][3][4], part_in [L][2][3][4];
   ptrc_pkg::dot_type    term_ff [L][2][3], term_in [L][2][3];
   ptrc_pkg::edge_type   edge4_ff [L], edge4_in [L];
   ptrc_pkg::edge_type   edge5_ff [L], edge6_ff [L];
   logic                 pos_ff [L][2], pos_in [L][2];
   ptrc_pkg::region_type code_ff, code_in;

   // per-stage advance: a stage moves when empty or when the next one moves
   always_comb begin
      en[N-1] = !v_ff[N-1] || !rsp_stall;
      for (int i = N - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
      v_in[0] = en[0] ? req_valid : v_ff[0];
      for (int i = 1; i < N; i++) begin
         v_in[i] = en[i] ? v_ff[i-1] : v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_stall       = !en[0];
   assign rsp_valid       = v_ff[N-1];
   assign rsp_region_code = code_ff;

   // stage 1: vectors from the test point to each vertex, per lane
   assign pt[0] = '{req_a_x, req_a_y, req_a_z};
   assign pt[1] = '{req_b_x, req_b_y, req_b_z};
   assign pt[2] = '{req_c_x, req_c_y, req_c_z};
   assign pt[3] = '{req_q_x, req_q_y, req_q_z};

   always_comb begin
      for (int l = 0; l < L; l++) begin
         for (int v = 0; v < 3; v++) begin
            for (int k = 0; k < 3; k++) begin
               diff_in[l][v][k] =
                  ptrc_pkg::DIFF_W'(pt[ptrc_pkg::LANE_PT[l][v]][k]) -
                  ptrc_pkg::DIFF_W'(pt[ptrc_pkg::LANE_PT[l][3]][k]);
            end
         end
      end
   end

   // stage 2: cross product multiplies
   always_comb begin
      for (int l = 0; l < L; l++) begin
         for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 3; k++) begin
               mul_in[l][c][k][0] =
                  diff_ff[l][ptrc_pkg::CROSS_U[c]][ptrc_pkg::NEXT1[k]] *
                  diff_ff[l][ptrc_pkg::CROSS_V[c]][ptrc_pkg::NEXT2[k]];
               mul_in[l][c][k][1] =
                  diff_ff[l][ptrc_pkg::CROSS_U[c]][ptrc_pkg::NEXT2[k]] *
                  diff_ff[l][ptrc_pkg::CROSS_V[c]][ptrc_pkg::NEXT1[k]];
            end
         end
      end
   end

   // stage 3: cross product components
   always_comb begin
      for (int l = 0; l < L; l++) begin
         for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 3; k++) begin
               cross_in[l][c][k] = ptrc_pkg::CROSS_W'(mul_ff[l][c][k][0]) -
                                   ptrc_pkg::CROSS_W'(mul_ff[l][c][k][1]);
            end
         end
      end
   end

   // stage 4: edge priority, and dot multiplies cut into four partials
   always_comb begin
      ptrc_pkg::half_type xh, xl, yh, yl;
      logic z12, z23, z31;
      for (int l = 0; l < L; l++) begin
         z12 = (cross_ff[l][0][0] == '0) && (cross_ff[l][0][1] == '0) &&
               (cross_ff[l][0][2] == '0);
         z23 = (cross_ff[l][1][0] == '0) && (cross_ff[l][1][1] == '0) &&
               (cross_ff[l][1][2] == '0);
         z31 = (cross_ff[l][2][0] == '0) && (cross_ff[l][2][1] == '0) &&
               (cross_ff[l][2][2] == '0);
         priority if (z12) edge4_in[l] = ptrc_pkg::EDGE_12;
         else if (z23)     edge4_in[l] = ptrc_pkg::EDGE_23;
         else if (z31)     edge4_in[l] = ptrc_pkg::EDGE_31;
         else              edge4_in[l] = ptrc_pkg::EDGE_NONE;
         for (int d = 0; d < 2; d++) begin
            for (int k = 0; k < 3; k++) begin
               xh = $signed(cross_ff[l][0][k][ptrc_pkg::CROSS_W-1:ptrc_pkg::LO_W]);
               xl = $signed({1'b0, cross_ff[l][0][k][ptrc_pkg::LO_W-1:0]});
               yh = $signed(cross_ff[l][ptrc_pkg::DOT_Y[d]][k]
                            [ptrc_pkg::CROSS_W-1:ptrc_pkg::LO_W]);
               yl = $signed({1'b0, cross_ff[l][ptrc_pkg::DOT_Y[d]][k]
                                   [ptrc_pkg::LO_W-1:0]});
               part_in[l][d][k][0] = xh * yh;
               part_in[l][d][k][1] = xh * yl;
               part_in[l][d][k][2] = xl * yh;
               part_in[l][d][k][3] = xl * yl;
            end
         end
      end
   end

   // stage 5: recombine partials into full products
   always_comb begin
      for (int l = 0; l < L; l++) begin
         for (int d = 0; d < 2; d++) begin
            for (int k = 0; k < 3; k++) begin
               term_in[l][d][k] =
                  (ptrc_pkg::DOT_W'(part_ff[l][d][k][0]) <<< (2 * ptrc_pkg::LO_W)) +
                  ((ptrc_pkg::DOT_W'(part_ff[l][d][k][1]) +
                    ptrc_pkg::DOT_W'(part_ff[l][d][k][2])) <<< ptrc_pkg::LO_W) +
                  ptrc_pkg::DOT_W'(part_ff[l][d][k][3]);
            end
         end
      end
   end

   // stage 6: dot sums, strictly positive test
   always_comb begin
      ptrc_pkg::dot_type sum;
      for (int l = 0; l < L; l++) begin
         for (int d = 0; d < 2; d++) begin
            sum = term_ff[l][d][0] + term_ff[l][d][1] + term_ff[l][d][2];
            pos_in[l][d] = !sum[ptrc_pkg::DOT_W-1] && (sum != '0);
         end
      end
   end

   // stage 7: region code from the main lane and the swapped-vertex lanes
   always_comb begin
      logic in_a, in_b, in_c;
      in_a = (edge6_ff[1] == ptrc_pkg::EDGE_NONE) && pos_ff[1][0] && pos_ff[1][1];
      in_b = (edge6_ff[2] == ptrc_pkg::EDGE_NONE) && pos_ff[2][0] && pos_ff[2][1];
      in_c = (edge6_ff[3] == ptrc_pkg::EDGE_NONE) && pos_ff[3][0] && pos_ff[3][1];
      priority if (edge6_ff[0] != ptrc_pkg::EDGE_NONE)
         code_in = ptrc_pkg::REGION_W'(edge6_ff[0]);
      else if (pos_ff[0][0]) begin
         if (pos_ff[0][1]) code_in = ptrc_pkg::REGION_INSIDE;
         else code_in = in_a ? ptrc_pkg::REGION_A_TRUE : ptrc_pkg::REGION_A_FALSE;
      end else if (pos_ff[0][1])
         code_in = in_b ? ptrc_pkg::REGION_B_TRUE : ptrc_pkg::REGION_B_FALSE;
      else
         code_in = in_c ? ptrc_pkg::REGION_C_TRUE : ptrc_pkg::REGION_C_FALSE;
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (en[0]) diff_ff <= diff_in;
      if (en[1]) mul_ff <= mul_in;
      if (en[2]) cross_ff <= cross_in;
      if (en[3]) begin
         part_ff  <= part_in;
         edge4_ff <= edge4_in;
      end
      if (en[4]) begin
         term_ff  <= term_in;
         edge5_ff <= edge4_ff;
      end
      if (en[5]) begin
         pos_ff   <= pos_in;
         edge6_ff <= edge5_ff;
      end
      if (en[6]) code_ff <= code_in;
   end

endmodule

### design/ptrc_checker.sv
// ----------------------------------------------------------------------------
// ptrc_checker
// Port-level checks of the region classifier, bound to its top level.
// ----------------------------------------------------------------------------
`include "point_triangle_region_classifier_assert.svh"

module ptrc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input ptrc_pkg::region_type rsp_region_code
);

   // codes above nine never leave the block
   `PTRC_ASSERT_IMPL(a_code_range, rsp_valid, rsp_region_code <= ptrc_pkg::REGION_C_FALSE, "region code out of range")
   // an empty output stage never holds off the input
   `PTRC_ASSERT_IMPL(a_no_stall_empty, !rsp_valid, !req_stall, "input stalled with output empty")
   // stalled result stays offered
   `PTRC_ASSERT_IMPL(a_rsp_hold, $past(rsp_valid && rsp_stall) && !$past(reset), rsp_valid, "result dropped under stall")
   // stalled result keeps its code
   `PTRC_ASSERT_IMPL(a_rsp_stable, $past(rsp_valid && rsp_stall) && !$past(reset), $stable(rsp_region_code), "result changed under stall")
   // reset empties the pipeline
   `PTRC_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> !rsp_valid, "result valid after reset")

endmodule

bind point_triangle_region_classifier ptrc_checker u_ptrc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_region_code (rsp_region_code)
);

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the point/triangle region classifier.
// ----------------------------------------------------------------------------
// A queue of triangles and query points is filled up front and fed by a
// clocked driver with random gaps. A clocked monitor stalls at random, takes
// each result transfer and checks it against a region predicted here with
// exact wide integer arithmetic. One long output hold-off lets the pipeline
// fill and push back on the input.
module tb_top;

   localparam int N_RANDOM  = 1930;
   localparam int MAX_CYCLE = 400000;
   localparam int LATENCY   = 7;

   typedef struct {
      ptrc_pkg::coord_type pt [4][3];   // a, b, c, q by x, y, z
   } query_type;

   typedef logic signed [127:0] wide_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   ptrc_pkg::coord_type  req_pt [4][3] = '{default: '0};
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   ptrc_pkg::region_type rsp_region_code;

   query_type            pending_q [$];
   ptrc_pkg::region_type region_q  [$];
   int         n_errors  = 0;
   int         n_checked = 0;
   int         n_inside  = 0;
   int         n_edge    = 0;
   int         n_outside = 0;
   int         cycle     = 0;
   int         send_wait;
   int         recv_wait;
   int         hold_off;
   bit         hold_done;
   bit         stim_done = 1'b0;

   point_triangle_region_classifier DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_a_x         (req_pt[0][0]),
      .req_a_y         (req_pt[0][1]),
      .req_a_z         (req_pt[0][2]),
      .req_b_x         (req_pt[1][0]),
      .req_b_y         (req_pt[1][1]),
      .req_b_z         (req_pt[1][2]),
      .req_c_x         (req_pt[2][0]),
      .req_c_y         (req_pt[2][1]),
      .req_c_z         (req_pt[2][2]),
      .req_q_x         (req_pt[3][0]),
      .req_q_y         (req_pt[3][1]),
      .req_q_z         (req_pt[3][2]),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_region_code (rsp_region_code)
   );

   // Clock
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Edge test on p1,p2,p3 about p: returns edge, and dot signs
   function automatic ptrc_pkg::edge_type edge_test(input wide_type p [4][3],
                                                    input int i1, input int i2,
                                                    input int i3, input int ip,
                                                    output bit pos31, output bit pos23);
      wide_type v [3][3];
      wide_type x [3][3];
      wide_type d31;
      wide_type d23;
      int    k;
      int    u;
      int    w;
      for (k = 0; k < 3; k++) begin
         v[0][k] = p[i1][k] - p[ip][k];
         v[1][k] = p[i2][k] - p[ip][k];
         v[2][k] = p[i3][k] - p[ip][k];
      end
      for (k = 0; k < 3; k++) begin
         u = k;
         w = (k + 1) % 3;
         x[k][0] = v[u][1] * v[w][2] - v[u][2] * v[w][1];
         x[k][1] = v[u][2] * v[w][0] - v[u][0] * v[w][2];
         x[k][2] = v[u][0] * v[w][1] - v[u][1] * v[w][0];
      end
      pos31 = 1'b0;
      pos23 = 1'b0;
      if (x[0][0] == 0 && x[0][1] == 0 && x[0][2] == 0) return ptrc_pkg::EDGE_12;
      if (x[1][0] == 0 && x[1][1] == 0 && x[1][2] == 0) return ptrc_pkg::EDGE_23;
      if (x[2][0] == 0 && x[2][1] == 0 && x[2][2] == 0) return ptrc_pkg::EDGE_31;
      d31 = x[0][0] * x[2][0] + x[0][1] * x[2][1] + x[0][2] * x[2][2];
      d23 = x[0][0] * x[1][0] + x[0][1] * x[1][1] + x[0][2] * x[1][2];
      pos31 = d31 > 0;
      pos23 = d23 > 0;
      return ptrc_pkg::EDGE_NONE;
   endfunction

   function automatic bit is_inside(input wide_type p [4][3], input int i1, input int i2,
                                    input int i3, input int ip);
      bit g1;
      bit g2;
      ptrc_pkg::edge_type e;
      e = edge_test(p, i1, i2, i3, ip, g1, g2);
      return e == ptrc_pkg::EDGE_NONE && g1 && g2;
   endfunction

   // Region predicted for one query
   function automatic ptrc_pkg::region_type predict_region(input query_type t);
      wide_type p [4][3];
      bit       g1;
      bit       g2;
      ptrc_pkg::edge_type e;
      for (int i = 0; i < 4; i++)
         for (int k = 0; k < 3; k++)
            p[i][k] = wide_type'(t.pt[i][k]);
      e = edge_test(p, 0, 1, 2, 3, g1, g2);
      if (e != ptrc_pkg::EDGE_NONE) return ptrc_pkg::region_type'(e);
      if (g1 && g2) return ptrc_pkg::REGION_INSIDE;
      if (g1) return is_inside(p, 3, 1, 2, 0) ? ptrc_pkg::REGION_A_TRUE
                                              : ptrc_pkg::REGION_A_FALSE;
      if (g2) return is_inside(p, 0, 3, 2, 1) ? ptrc_pkg::REGION_B_TRUE
                                              : ptrc_pkg::REGION_B_FALSE;
      return is_inside(p, 0, 1, 3, 2) ? ptrc_pkg::REGION_C_TRUE : ptrc_pkg::REGION_C_FALSE;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle, what);
      n_errors++;
   endtask

   // Coordinate drawn from full range, a small window or the extremes
   function automatic ptrc_pkg::coord_type draw_coord(input int span);
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 4) return ptrc_pkg::coord_type'($urandom);
      if (sel == 9) return $urandom_range(0, 1) ? ptrc_pkg::coord_type'(16'h7fff)
                                                : ptrc_pkg::coord_type'(16'h8000);
      return ptrc_pkg::coord_type'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   task automatic push_query(input query_type t);
      pending_q.push_back(t);
   endtask

   // Random query of some shape: general, on an edge, in a plane, coincident points
   task automatic push_random();
      query_type t;
      int     shape;
      int     span;
      int     e;
      span  = $urandom_range(0, 1) ? 8 : 2000;
      shape = $urandom_range(0, 9);
      for (int i = 0; i < 4; i++)
         for (int k = 0; k < 3; k++)
            t.pt[i][k] = draw_coord(span);
      if (shape < 3) begin
         // coplanar: all z equal, so inside and outside cases are common
         for (int i = 0; i < 4; i++) t.pt[i][2] = t.pt[0][2];
      end else if (shape == 3) begin
         // query on an edge line: midpoint-like integer point
         e = $urandom_range(0, 2);
         for (int k = 0; k < 3; k++)
            t.pt[3][k] = ptrc_pkg::coord_type'((int'(t.pt[e][k]) +
                                                int'(t.pt[(e+1)%3][k])) >>> 1);
         for (int k = 0; k < 3; k++)
            t.pt[(e+1)%3][k] = ptrc_pkg::coord_type'(2*int'(t.pt[3][k])
                                                     - int'(t.pt[e][k]));
      end else if (shape == 4) begin
         // coincident points
         e = $urandom_range(0, 3);
         t.pt[e] = t.pt[(e + 1) % 4];
      end
      push_query(t);
   endtask

   task automatic push_directed();
      query_type t;
      ptrc_pkg::coord_type ext [4];
      ext = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
      // plain triangle in z=0 and several query positions
      t.pt = '{'{0, 0, 0}, '{100, 0, 0}, '{0, 100, 0}, '{10, 10, 0}};
      push_query(t);
      foreach (ext[i]) begin
         t.pt = '{'{0, 0, 0}, '{100, 0, 0}, '{0, 100, 0}, '{-50, -50, 0}};
         push_query(t);
         break;
      end
      t.pt = '{'{0, 0, 0}, '{100, 0, 0}, '{0, 100, 0}, '{200, -50, 0}};  push_query(t);
      t.pt = '{'{0, 0, 0}, '{100, 0, 0}, '{0, 100, 0}, '{-50, 200, 0}};  push_query(t);
      t.pt = '{'{0, 0, 0}, '{100, 0, 0}, '{0, 100, 0}, '{200, 200, 0}};  push_query(t);
      t.pt = '{'{0, 0, 0}, '{100, 0, 0}, '{0, 100, 0}, '{-10, 50, 0}};   push_query(t);
      t.pt = '{'{0, 0, 0}, '{100, 0, 0}, '{0, 100, 0}, '{50, -10, 0}};   push_query(t);
      t.pt = '{'{0, 0, 0}, '{100, 0, 0}, '{0, 100, 0}, '{10, 10, 30}};   push_query(t);
      // query on each edge line, and on vertices (edge priority)
      t.pt = '{'{0, 0, 0}, '{100, 0, 0}, '{0, 100, 0}, '{50, 0, 0}};     push_query(t);
      t.pt = '{'{0, 0, 0}, '{100, 0, 0}, '{0, 100, 0}, '{50, 50, 0}};    push_query(t);
      t.pt = '{'{0, 0, 0}, '{100, 0, 0}, '{0, 100, 0}, '{0, 50, 0}};     push_query(t);
      t.pt = '{'{0, 0, 0}, '{100, 0, 0}, '{0, 100, 0}, '{0, 0, 0}};      push_query(t);
      t.pt = '{'{0, 0, 0}, '{100, 0, 0}, '{0, 100, 0}, '{100, 0, 0}};    push_query(t);
      // degenerate triangles: all equal, collinear
      t.pt = '{'{5, 5, 5}, '{5, 5, 5}, '{5, 5, 5}, '{1, 2, 3}};          push_query(t);
      t.pt = '{'{0, 0, 0}, '{1, 1, 1}, '{2, 2, 2}, '{7, -3, 2}};         push_query(t);
      // extreme coordinates everywhere
      for (int s = 0; s < 8; s++) begin
         for (int i = 0; i < 4; i++)
            for (int k = 0; k < 3; k++)
               t.pt[i][k] = ext[(s + i * 3 + k + (s > 3 ? i : 0)) % 4];
         push_query(t);
      end
      t.pt = '{'{-32768, -32768, 0}, '{32767, -32768, 0}, '{-32768, 32767, 0},
               '{32767, 32767, 0}};
      push_query(t);
   endtask

   // Stimulus
   initial begin
      push_directed();
      for (int n = 0; n < N_RANDOM; n++) push_random();
   end

   // Reset and end of run
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done && region_q.size() == 0);
      repeat (LATENCY * 4) @(posedge clock);
      $display("checked %0d results: %0d inside, %0d on edge lines, %0d outside",
               n_checked, n_inside, n_edge, n_outside);
      if (n_errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Timeout
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > MAX_CYCLE) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
         stim_done <= 1'b0;
      end else if (req_valid && !req_stall) begin
         region_q.push_back(predict_region(pending_q.pop_front()));
         if (pending_q.size() == 0) begin
            req_valid <= 1'b0;
            stim_done <= 1'b1;
         end else begin
            send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if ($urandom_range(0, 1) == 0) begin
               req_valid <= 1'b1;
               req_pt    <= pending_q[0].pt;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end else if (!req_valid && pending_q.size() != 0) begin
         if (send_wait == 0) begin
            req_valid <= 1'b1;
            req_pt    <= pending_q[0].pt;
         end else begin
            send_wait <= send_wait - 1;
         end
      end
   end

   // Long output hold-off, counted in cycles
   always @(posedge clock) begin
      if (reset) begin
         hold_off  <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && n_checked >= 300) begin
         hold_done <= 1'b1;
         hold_off  <= 200;
      end else if (hold_off != 0) begin
         hold_off  <= hold_off - 1;
      end
   end

   // Monitor with random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (region_q.size() == 0) begin
               report_mismatch($sformatf("unexpected region %0d", rsp_region_code));
            end else begin
               if (rsp_region_code !== region_q[0])
                  report_mismatch($sformatf("region %0d, expected %0d",
                                            rsp_region_code, region_q[0]));
               if (region_q[0] == ptrc_pkg::REGION_INSIDE) n_inside++;
               else if (region_q[0] < ptrc_pkg::REGION_A_TRUE) n_edge++;
               else n_outside++;
               void'(region_q.pop_front());
               n_checked++;
            end
         end
         if (hold_off != 0) begin
            rsp_stall <= 1'b1;
         end else if (recv_wait != 0) begin
            recv_wait <= recv_wait - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (rsp_valid && !rsp_stall)
               recv_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
         end
      end
   end

endmodule

### files.f
+incdir+design
design/ptrc_pkg.sv
design/point_triangle_region_classifier.sv
design/ptrc_checker.sv
bench/tb_top.sv
